>>> rtl/bale_pkg.sv
// Shared types, constants and control structs for the bounded array list engine.
package bale_pkg;

	// Store geometry
	localparam int DEPTH     = 1024;
	localparam int WORD_BITS = 32;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);

	// Fixed field widths of the transactions
	localparam int KIND_W = 3;
	localparam int POS_W  = 10;
	localparam int OUT_W  = 32;
	localparam int LEN_W  = 11;
	localparam int STAT_W = 2;

	// Request kinds
	localparam logic [KIND_W-1:0] REQ_APPEND = 3'd0;
	localparam logic [KIND_W-1:0] REQ_INSERT = 3'd1;
	localparam logic [KIND_W-1:0] REQ_REMOVE = 3'd2;
	localparam logic [KIND_W-1:0] REQ_GET    = 3'd3;
	localparam logic [KIND_W-1:0] REQ_SET    = 3'd4;

	// Response status codes
	localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_BAD_INDEX = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0]       req_type;
		logic [POS_W-1:0]        position;
		logic signed [OUT_W-1:0] word_in;
	} req_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] word_out;
		logic [LEN_W-1:0]        list_length;
		logic [STAT_W-1:0]       status;
	} rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_req;     // latch the accepted request
		logic decode;       // latch status, clear result word, preset pointer
		logic wr_word;      // write the request word to the store
		logic wr_at_count;  // write address is the list end, else the position
		logic shift;        // one step of the move loop
		logic capture;      // take the read word as the result word
		logic cnt_inc;
		logic cnt_dec;
		logic finish;       // load the response register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              reject;      // request fails its checks
		logic              shift_last;  // pointer at the last entry to move
		logic              remove_last; // removed entry is the final one
		logic              out_free;    // response register can take a result
	} sts_t;

endpackage

>>> rtl/bale_dp.sv
// Datapath: list store, entry count, move pointer and response register.
module bale_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  bale_pkg::req_t   req,
	input  bale_pkg::cmd_t   cmd,
	output bale_pkg::sts_t   sts,
	output bale_pkg::rsp_t   rsp,
	output logic             rsp_valid,
	input  logic             rsp_ready
);

	bale_pkg::req_t                        req_q;
	logic [bale_pkg::CNT_W-1:0]            count_q;
	logic [bale_pkg::ADDR_W-1:0]           ptr_q;
	logic                                  wr_pend_s1;
	logic [bale_pkg::ADDR_W-1:0]           wr_addr_s1;
	logic [bale_pkg::WORD_BITS-1:0]        rdata_q;
	logic signed [bale_pkg::OUT_W-1:0]     res_word_q;
	logic [bale_pkg::STAT_W-1:0]           res_status_q;
	bale_pkg::rsp_t                        rsp_q;
	logic                                  rsp_valid_q;

	logic [bale_pkg::WORD_BITS-1:0]        mem [bale_pkg::DEPTH];

	logic [bale_pkg::ADDR_W-1:0]           pos;
	logic [bale_pkg::ADDR_W-1:0]           last_idx;
	logic                                  in_range;
	logic                                  full;
	logic [bale_pkg::STAT_W-1:0]           status_calc;
	logic                                  is_insert;
	logic                                  we;
	logic [bale_pkg::ADDR_W-1:0]           waddr;
	logic [bale_pkg::WORD_BITS-1:0]        wdata;
	logic [bale_pkg::ADDR_W-1:0]           raddr;

	// Request checks
	assign pos       = bale_pkg::ADDR_W'(req_q.position);
	assign last_idx  = bale_pkg::ADDR_W'(count_q - bale_pkg::CNT_W'(1));
	assign in_range  = int'(req_q.position) < int'(count_q);
	assign full      = count_q == bale_pkg::CNT_W'(bale_pkg::DEPTH);
	assign is_insert = req_q.req_type == bale_pkg::REQ_INSERT;

	always_comb begin
		case (req_q.req_type)
			bale_pkg::REQ_APPEND: begin
				status_calc = full ? bale_pkg::STATUS_FULL : bale_pkg::STATUS_OK;
			end
			bale_pkg::REQ_INSERT: begin
				if (!in_range) begin
					status_calc = bale_pkg::STATUS_BAD_INDEX;
				end else if (full) begin
					status_calc = bale_pkg::STATUS_FULL;
				end else begin
					status_calc = bale_pkg::STATUS_OK;
				end
			end
			bale_pkg::REQ_REMOVE, bale_pkg::REQ_GET, bale_pkg::REQ_SET: begin
				status_calc = in_range ? bale_pkg::STATUS_OK : bale_pkg::STATUS_BAD_INDEX;
			end
			default: begin
				status_calc = bale_pkg::STATUS_BAD_INDEX;
			end
		endcase
	end

	assign sts.kind        = req_q.req_type;
	assign sts.reject      = status_calc != bale_pkg::STATUS_OK;
	assign sts.shift_last  = is_insert ? (ptr_q == pos) : (ptr_q == last_idx);
	assign sts.remove_last = int'(req_q.position) + 1 == int'(count_q);
	assign sts.out_free    = !rsp_valid_q || rsp_ready;

	// Store ports: a pending moved word has the write port, else the request word
	assign we    = wr_pend_s1 || cmd.wr_word;
	assign waddr = wr_pend_s1 ? wr_addr_s1 :
		(cmd.wr_at_count ? bale_pkg::ADDR_W'(count_q) : pos);
	assign wdata = wr_pend_s1 ? rdata_q : bale_pkg::WORD_BITS'(req_q.word_in);
	assign raddr = cmd.shift ? ptr_q : pos;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// Request, pointer and result payload
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
		end
		if (cmd.decode) begin
			res_status_q <= status_calc;
			res_word_q   <= '0;
			ptr_q        <= is_insert ? last_idx : pos + bale_pkg::ADDR_W'(1);
		end else if (cmd.shift) begin
			ptr_q <= is_insert ? ptr_q - bale_pkg::ADDR_W'(1) : ptr_q + bale_pkg::ADDR_W'(1);
		end
		if (cmd.shift) begin
			wr_addr_s1 <= is_insert ? ptr_q + bale_pkg::ADDR_W'(1) : ptr_q - bale_pkg::ADDR_W'(1);
		end
		if (cmd.capture) begin
			res_word_q <= bale_pkg::OUT_W'($signed(rdata_q));
		end
		if (cmd.finish) begin
			rsp_q.word_out    <= res_word_q;
			rsp_q.list_length <= bale_pkg::LEN_W'(count_q);
			rsp_q.status      <= res_status_q;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			wr_pend_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			wr_pend_s1 <= cmd.shift;
			if (cmd.cnt_inc) begin
				count_q <= count_q + bale_pkg::CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - bale_pkg::CNT_W'(1);
			end
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

>>> rtl/bale_ctrl.sv
// Controller: sequences decode, reads, writes, the move loop and the response.
module bale_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  bale_pkg::sts_t   sts,
	output bale_pkg::cmd_t   cmd
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_DECODE = 7'b0000010,
		ST_RDWAIT = 7'b0000100,
		ST_SHIFT  = 7'b0001000,
		ST_DRAIN  = 7'b0010000,
		ST_PUTW   = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				if (sts.reject) begin
					state_d = ST_DONE;
				end else begin
					case (sts.kind)
						bale_pkg::REQ_APPEND: begin
							cmd.wr_word     = 1'b1;
							cmd.wr_at_count = 1'b1;
							cmd.cnt_inc     = 1'b1;
							state_d         = ST_DONE;
						end
						bale_pkg::REQ_SET: begin
							cmd.wr_word = 1'b1;
							state_d     = ST_DONE;
						end
						bale_pkg::REQ_INSERT: begin
							state_d = ST_SHIFT;
						end
						default: begin
							// get and remove read the entry at the position
							state_d = ST_RDWAIT;
						end
					endcase
				end
			end
			ST_RDWAIT: begin
				cmd.capture = 1'b1;
				if (sts.kind == bale_pkg::REQ_GET) begin
					state_d = ST_DONE;
				end else if (sts.remove_last) begin
					cmd.cnt_dec = 1'b1;
					state_d     = ST_DONE;
				end else begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				if (sts.shift_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last moved word is written this cycle
				if (sts.kind == bale_pkg::REQ_INSERT) begin
					state_d = ST_PUTW;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d     = ST_DONE;
				end
			end
			ST_PUTW: begin
				cmd.wr_word = 1'b1;
				cmd.cnt_inc = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/bounded_array_list_engine_unit.sv
// Top level of the bounded array list engine: controller plus datapath.
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  bale_pkg::req_t (req_type, position, word_in)
//  rsp      out        rsp_valid / rsp_ready  bale_pkg::rsp_t (word_out, list_length, status)
//
// One transaction at a time. Append, set and rejected requests go from decode straight to the
// response; get first reads the entry; insert moves the entries from the position to the list
// end up by one, then writes the new word; remove reads the entry, then moves the later entries
// down by one, unless the last entry goes. The next request can be taken in the cycle after the
// response is loaded; the one-entry-per-cycle move loop sets the worst-case transaction time.
// Reset clears the entry count and control only; the store needs no clearing pass.
// The response register holds a finished result while rsp_ready is low; the next
// request is accepted meanwhile and waits only at its own response.
module bounded_array_list_engine_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  bale_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output bale_pkg::rsp_t rsp
);

	bale_pkg::cmd_t cmd;
	bale_pkg::sts_t sts;

	bale_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bale_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);

`ifndef SYNTHESIS
	// one transaction in flight: no accept right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while one is in flight");

	// length never exceeds the store depth
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (int'(rsp.list_length) <= bale_pkg::DEPTH))
		else $error("list length beyond store depth");

	// a full report only with the store at depth
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == bale_pkg::STATUS_FULL)
			|-> (int'(rsp.list_length) == bale_pkg::DEPTH))
		else $error("full status with free entries");

	// rejected requests return no word
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != bale_pkg::STATUS_OK) |-> (rsp.word_out == '0))
		else $error("word returned on a rejected request");
`endif

endmodule
